>>> src/brcp_pkg.sv
`default_nettype none
package brcp_pkg;

	// store depth, a power of two
	localparam int unsigned STORE_DEPTH = 256;
	localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

	localparam logic [15:0] CMD_LOAD_RD_ADDR = 16'h0011;
	localparam logic [15:0] CMD_LOAD_WR_DATA = 16'h0012;
	localparam logic [15:0] CMD_LOAD_WR_ADDR = 16'h0020;
	localparam logic [15:0] CMD_STORE        = 16'h0021;
	localparam logic [15:0] CMD_FETCH        = 16'h0022;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [2:0] {
		MODE_IDLE     = 3'd0,
		MODE_RD_ADDR  = 3'd1,
		MODE_WR_ADDR  = 3'd2,
		MODE_WR_DATA  = 3'd3,
		MODE_RD_ARMED = 3'd4
	} mode_t;

	function automatic logic [STORE_AW-1:0] store_index(input logic [7:0] addr);
		logic [STORE_AW+7:0] wide;
		wide = {{STORE_AW{1'b0}}, addr};
		return wide[STORE_AW-1:0];
	endfunction

endpackage
`default_nettype wire

>>> src/backup_ram_command_port_top.sv
// Command-driven port in front of a battery-backed byte store, cleared at reset. Each bus
// access (opcode 1 write, 0 read) gives exactly one read_data item: the latched byte in the
// upper half on a read after a fetch command, zero otherwise. An item is registered on
// acceptance, then decoded and applied to the mode and store as it leaves that register,
// and its result is held in an output register, so a new item is taken every cycle while
// the output register is empty or out_ready is high. The store is cleared through
// per-entry valid flags, so there is no clearing pass after reset.
`default_nettype none
module backup_ram_command_port_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        opcode,
	input  wire logic [15:0] write_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      read_data
);
	import brcp_pkg::*;

	logic        valid_s1;
	logic        opcode_s1;
	logic [15:0] write_data_s1;
	logic        advance;

	mode_t       mode_q;
	mode_t       mode_d;
	logic [8:0]  read_address_q;
	logic [7:0]  write_address_q;
	logic [7:0]  write_byte_q;
	logic [7:0]  read_byte_q;
	logic        out_valid_q;
	logic [15:0] read_data_q;

	logic        rd_addr_we;
	logic        wr_addr_we;
	logic        wr_byte_we;
	logic        store_we;
	logic        fetch_en;
	logic [15:0] result;

	logic [7:0]             store_mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] entry_valid_q;
	logic [STORE_AW-1:0]    wr_idx;
	logic [STORE_AW-1:0]    rd_idx;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign wr_idx    = store_index(write_address_q);
	assign rd_idx    = store_index(read_address_q[8:1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1     <= opcode;
			write_data_s1 <= write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else begin
			mode_q <= mode_d;
		end
	end

	always_comb begin
		mode_d     = mode_q;
		rd_addr_we = 1'b0;
		wr_addr_we = 1'b0;
		wr_byte_we = 1'b0;
		store_we   = 1'b0;
		fetch_en   = 1'b0;
		result     = '0;
		if (advance) begin
			if (opcode_s1 == OP_WRITE) begin
				case (mode_q)
					MODE_IDLE: begin
						case (write_data_s1)
							CMD_LOAD_RD_ADDR: mode_d = MODE_RD_ADDR;
							CMD_LOAD_WR_DATA: mode_d = MODE_WR_DATA;
							CMD_LOAD_WR_ADDR: mode_d = MODE_WR_ADDR;
							CMD_STORE:        store_we = 1'b1;
							CMD_FETCH: begin
								fetch_en = 1'b1;
								mode_d   = MODE_RD_ARMED;
							end
							default: ;
						endcase
					end
					MODE_RD_ADDR: begin
						rd_addr_we = 1'b1;
						mode_d     = MODE_IDLE;
					end
					MODE_WR_ADDR: begin
						wr_addr_we = 1'b1;
						mode_d     = MODE_IDLE;
					end
					MODE_WR_DATA: begin
						wr_byte_we = 1'b1;
						mode_d     = MODE_IDLE;
					end
					default: ;
				endcase
			end else if (mode_q == MODE_RD_ARMED) begin
				result = {read_byte_q, 8'h00};
				mode_d = MODE_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_address_q  <= '0;
			write_address_q <= '0;
			write_byte_q    <= '0;
			read_byte_q     <= '0;
			entry_valid_q   <= '0;
		end else begin
			if (rd_addr_we) begin
				read_address_q <= write_data_s1[8:0];
			end
			if (wr_addr_we) begin
				write_address_q <= write_data_s1[7:0];
			end
			if (wr_byte_we) begin
				write_byte_q <= write_data_s1[7:0];
			end
			if (store_we) begin
				entry_valid_q[wr_idx] <= 1'b1;
			end
			if (fetch_en) begin
				read_byte_q <= entry_valid_q[rd_idx] ? store_mem[rd_idx] : 8'h00;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[wr_idx] <= write_byte_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= result;
		end
	end

	// an input stall only happens with an item waiting in the decode stage
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1)
		else $error("input stalled with empty decode stage");

	// writes always answer zero
	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && opcode_s1 == OP_WRITE) |=> (read_data_q == 16'h0000))
		else $error("write item gave nonzero result");

	// a read in read-armed mode consumes the arm
	a_read_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && opcode_s1 == OP_READ && mode_q == MODE_RD_ARMED) |=> (mode_q == MODE_IDLE))
		else $error("read did not return port to idle");

	// fetch arms the read
	a_fetch_arms: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_en |=> (mode_q == MODE_RD_ARMED))
		else $error("fetch did not arm a read");

endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps
module tb;
	import brcp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 6;
	localparam int MAX_REPORTS    = 10;

	localparam logic [15:0] COMMANDS [5] = '{CMD_LOAD_RD_ADDR, CMD_LOAD_WR_DATA,
		CMD_LOAD_WR_ADDR, CMD_STORE, CMD_FETCH};

	typedef struct packed {
		logic        op;
		logic [15:0] word;
		logic        known;
		logic [15:0] value;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        opcode;
	logic [15:0] write_data;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] read_data;

	// typed expectation travels with the item
	logic        row_known;
	logic [15:0] row_value;

	// shadow copy of the port state
	mode_t       cur_mode;
	logic [8:0]  rd_addr;
	logic [7:0]  wr_addr;
	logic [7:0]  wr_byte;
	logic [7:0]  rd_byte;
	logic [7:0]  shadow_store [STORE_DEPTH];

	logic [15:0] read_q [$];

	int unsigned n_items;
	int unsigned n_results;
	int unsigned n_byte_reads;
	int unsigned errors;
	int unsigned quiet_cycles;
	int          src_odds;
	int          sink_odds;
	int          sink_stall;
	int          sink_hold;

	script_row_t script [0:25] = '{
		'{OP_READ,  16'h0000, 1'b1, 16'h0000},
		'{OP_WRITE, CMD_FETCH, 1'b1, 16'h0000},
		'{OP_READ,  16'hffff, 1'b1, 16'h0000},
		'{OP_READ,  16'h0000, 1'b1, 16'h0000},
		'{OP_WRITE, CMD_LOAD_WR_ADDR, 1'b1, 16'h0000},
		'{OP_WRITE, 16'hffff, 1'b1, 16'h0000},
		'{OP_WRITE, CMD_LOAD_WR_DATA, 1'b1, 16'h0000},
		'{OP_WRITE, 16'hffff, 1'b1, 16'h0000},
		'{OP_WRITE, CMD_STORE, 1'b1, 16'h0000},
		'{OP_WRITE, CMD_LOAD_RD_ADDR, 1'b1, 16'h0000},
		'{OP_WRITE, 16'h01ff, 1'b1, 16'h0000},
		'{OP_WRITE, CMD_FETCH, 1'b1, 16'h0000},
		'{OP_WRITE, CMD_STORE, 1'b1, 16'h0000},
		'{OP_READ,  16'h0000, 1'b1, 16'hff00},
		'{OP_READ,  16'h0000, 1'b1, 16'h0000},
		'{OP_WRITE, CMD_LOAD_RD_ADDR | 16'h0100, 1'b1, 16'h0000},
		'{OP_WRITE, CMD_LOAD_WR_ADDR, 1'b1, 16'h0000},
		'{OP_READ,  16'h5a5a, 1'b1, 16'h0000},
		'{OP_WRITE, 16'h0000, 1'b1, 16'h0000},
		'{OP_WRITE, CMD_LOAD_WR_DATA, 1'b1, 16'h0000},
		'{OP_WRITE, 16'h00a5, 1'b1, 16'h0000},
		'{OP_WRITE, CMD_STORE, 1'b1, 16'h0000},
		'{OP_WRITE, CMD_LOAD_RD_ADDR, 1'b1, 16'h0000},
		'{OP_WRITE, 16'hfe00, 1'b1, 16'h0000},
		'{OP_WRITE, CMD_FETCH, 1'b1, 16'h0000},
		'{OP_READ,  16'h0000, 1'b1, 16'ha500}
	};

	backup_ram_command_port_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data)
	);

	always #6 clk = ~clk;

	function automatic logic [15:0] port_access(input logic op, input logic [15:0] word);
		logic [15:0] result;
		result = '0;
		if (op == OP_WRITE) begin
			case (cur_mode)
			MODE_IDLE: begin
				if (word == CMD_LOAD_RD_ADDR)
					cur_mode = MODE_RD_ADDR;
				else if (word == CMD_LOAD_WR_DATA)
					cur_mode = MODE_WR_DATA;
				else if (word == CMD_LOAD_WR_ADDR)
					cur_mode = MODE_WR_ADDR;
				else if (word == CMD_STORE)
					shadow_store[wr_addr % STORE_DEPTH] = wr_byte;
				else if (word == CMD_FETCH) begin
					rd_byte = shadow_store[(rd_addr >> 1) % STORE_DEPTH];
					cur_mode = MODE_RD_ARMED;
				end
			end
			MODE_RD_ADDR: begin
				rd_addr = word[8:0];
				cur_mode = MODE_IDLE;
			end
			MODE_WR_ADDR: begin
				wr_addr = word[7:0];
				cur_mode = MODE_IDLE;
			end
			MODE_WR_DATA: begin
				wr_byte = word[7:0];
				cur_mode = MODE_IDLE;
			end
			default: begin
			end
			endcase
		end else if (cur_mode == MODE_RD_ARMED) begin
			result = {rd_byte, 8'h00};
			cur_mode = MODE_IDLE;
		end
		return result;
	endfunction

	task automatic note_mismatch(input string what, input logic [15:0] want,
		input logic [15:0] got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s read_data expected %h got %h", $realtime, what, want, got);
	endtask

	// accept and check on the rising edge, watchdog alongside
	always @(posedge clk) begin
		logic [15:0] want;
		logic [15:0] model_out;
		if (in_valid && in_ready) begin
			model_out = port_access(opcode, write_data);
			read_q.push_back(row_known ? row_value : model_out);
		end
		if (out_valid && out_ready) begin
			n_results++;
			if (read_data != '0)
				n_byte_reads++;
			if (read_q.size() == 0)
				note_mismatch("unexpected item", '0, read_data);
			else begin
				want = read_q.pop_front();
				if (read_data !== want)
					note_mismatch("mismatch", want, read_data);
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
			$display("tb NOT OK");
			$finish;
		end
	end

	// result side: random stall bursts and the long hold-off
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				out_ready <= 1'b0;
				sink_hold--;
			end else if (sink_stall > 0) begin
				out_ready <= 1'b0;
				sink_stall--;
			end else if (sink_odds != 0 && $urandom_range(1, sink_odds) == 1) begin
				out_ready <= 1'b0;
				sink_stall = $urandom_range(1, 18) - 1;
			end else
				out_ready <= 1'b1;
		end
	end

	task automatic send_access(input logic op, input logic [15:0] word,
		input logic known = 1'b0, input logic [15:0] value = '0);
		@(negedge clk);
		if (src_odds != 0 && $urandom_range(1, src_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		write_data <= word;
		row_known  <= known;
		row_value  <= value;
		do
			@(posedge clk);
		while (!in_ready);
		n_items++;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (read_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [15:0] near_address(input logic rd_side);
		logic [15:0] w;
		w = 16'($urandom);
		if ($urandom_range(0, 3) != 0) begin
			if (rd_side)
				w[8:1] = 8'($urandom_range(0, 15));
			else
				w[7:0] = 8'($urandom_range(0, 15));
		end
		return w;
	endfunction

	task automatic random_burst();
		int pick;
		logic [15:0] w;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			send_access(OP_WRITE, CMD_LOAD_RD_ADDR);
			send_access(OP_WRITE, near_address(1'b1));
		end else if (pick < 30) begin
			send_access(OP_WRITE, CMD_LOAD_WR_ADDR);
			send_access(OP_WRITE, near_address(1'b0));
		end else if (pick < 45) begin
			send_access(OP_WRITE, CMD_LOAD_WR_DATA);
			send_access(OP_WRITE, 16'($urandom));
		end else if (pick < 60)
			send_access(OP_WRITE, CMD_STORE);
		else if (pick < 80) begin
			send_access(OP_WRITE, CMD_FETCH);
			repeat ($urandom_range(0, 3) / 2)
				send_access(OP_WRITE, $urandom_range(0, 1) ? COMMANDS[$urandom_range(0, 4)]
					: 16'($urandom));
			send_access(OP_READ, 16'($urandom));
		end else if (pick < 90)
			send_access(OP_READ, 16'($urandom));
		else begin
			w = COMMANDS[$urandom_range(0, 4)];
			case ($urandom_range(0, 2))
			0: w = 16'($urandom);
			1: w = w ^ (16'h0001 << $urandom_range(0, 15));
			default: begin
			end
			endcase
			send_access(1'($urandom), w);
		end
	endtask

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		opcode     = OP_READ;
		write_data = '0;
		row_known  = 1'b0;
		row_value  = '0;
		cur_mode   = MODE_IDLE;
		rd_addr    = '0;
		wr_addr    = '0;
		wr_byte    = '0;
		rd_byte    = '0;
		foreach (shadow_store[i])
			shadow_store[i] = '0;
		n_items      = 0;
		n_results    = 0;
		n_byte_reads = 0;
		errors       = 0;
		quiet_cycles = 0;
		src_odds     = 0;
		sink_odds    = 0;
		sink_stall   = 0;
		sink_hold    = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_access(script[i].op, script[i].word, script[i].known, script[i].value);
		settle();

		src_odds  = 4;
		sink_odds = 4;
		while (n_items < 700)
			random_burst();

		src_odds  = 0;
		sink_odds = 0;
		while (n_items < 900)
			random_burst();

		sink_hold = HOLD_CYCLES;
		while (n_items < 1000)
			random_burst();
		settle();

		src_odds  = 3;
		sink_odds = 6;
		while (n_items < 1500)
			random_burst();
		settle();

		src_odds  = 0;
		sink_odds = 0;
		while (n_items < 1830)
			random_burst();
		settle();

		$display("%0d accesses, %0d results, %0d reads returned a stored byte", n_items,
			n_results, n_byte_reads);
		$display("random command sequences with idle bursts, a %0d-cycle output hold-off",
			HOLD_CYCLES);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
